@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
// both macros expect clk in scope; ASSERT_CLKD also expects rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/cpsc_pkg.sv @@
package cpsc_pkg;

  // fixed field widths
  localparam int ELEM_W = 6;
  localparam int MOD_W  = 7;

  // working width for modulus compares and sums, covers every legal MAX_MODULUS
  localparam int CMP_W = 9;

  // config port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register indexes
  typedef enum logic [0:0] {
    REG_MODULUS = 1'b0
  } cpsc_reg_t;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 7'd8;

endpackage

@@ rtl/cyclic_partial_sum_sequencing_check.sv @@
// Checks candidate orderings of the nonzero residues mod n, one element per
// transaction; an ordering is n-1 elements long, with n taken from the modulus
// register and saturated to 2..MAX_MODULUS. An ordering fails when a partial
// sum is zero, repeats, or equals floor(n/2) before the last element; an
// element not below n fails it and sets bad_element. After the last element one
// verdict transaction is produced and the per-ordering state is cleared. The
// block takes one element every cycle: an element is registered at the input,
// then combinational logic (modular add, one bitmap bit test) updates the
// running sum and bitmap and, on the last element, loads the result register.
// The last element of an ordering passes the input register and then loads the
// result register, which holds the verdict. The input stalls only when a last
// element finds the previous verdict still held by a stalled output. Write the
// modulus only while no element is held in the input register; an ordering in
// progress keeps its sum, bitmap and position and ends at the first element
// whose position is n-2 or more under the new n.
`include "assert_macros.svh"

module cyclic_partial_sum_sequencing_check
  import cpsc_pkg::*;
#(
  parameter int MAX_MODULUS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // element stream
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ELEM_W-1:0] in_element,
  // verdict stream
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_constructive,
  output logic              out_bad_element,
  // config port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int SUM_W = (MAX_MODULUS > 2) ? $clog2(MAX_MODULUS) : 1;
  localparam int POS_W = SUM_W;
  localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_MODULUS);
  localparam logic [CMP_W-1:0] MIN_N = CMP_W'(2);

  // config register
  logic [MOD_W-1:0] modulus_r;
  logic             cfg_wr;
  cpsc_reg_t        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cpsc_reg_t'(cfg_paddr[APB_AW-1]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_wr && (cfg_idx == REG_MODULUS)) begin
      modulus_r <= cfg_pwdata[MOD_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODULUS: cfg_prdata = APB_DW'(modulus_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // input register
  logic              s1_valid_r;
  logic [ELEM_W-1:0] s1_elem_r;
  logic              in_accept;
  logic              advance;

  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_elem_r <= in_element;
    end
  end

  // per-ordering state
  logic [SUM_W-1:0]       sum_r,  sum_nxt;
  logic [MAX_MODULUS-1:0] seen_r, seen_nxt;
  logic [POS_W-1:0]       pos_r,  pos_nxt;
  logic                   rej_r,  rej_nxt;
  logic                   oor_r,  oor_nxt;

  // effective modulus and derived limits
  logic [CMP_W-1:0] mod_ext;
  logic [CMP_W-1:0] n_eff;
  logic [CMP_W-1:0] n_half;
  logic             last;

  assign mod_ext = CMP_W'(modulus_r);
  assign n_eff   = (mod_ext < MIN_N) ? MIN_N : ((mod_ext > MAX_N) ? MAX_N : mod_ext);
  assign n_half  = n_eff >> 1;
  assign last    = CMP_W'(pos_r) >= (n_eff - MIN_N);

  // modular add and bitmap test
  logic [CMP_W-1:0] elem_ext;
  logic [CMP_W-1:0] sum_raw;
  logic [CMP_W-1:0] sum_mod;
  logic [SUM_W-1:0] sum_idx;
  logic             out_free;
  logic             verdict_load;
  logic             rej_item;
  logic             oor_item;

  assign elem_ext = CMP_W'(s1_elem_r);
  assign sum_raw  = CMP_W'(sum_r) + elem_ext;
  assign sum_mod  = (sum_raw >= n_eff) ? (sum_raw - n_eff) : sum_raw;
  assign sum_idx  = sum_mod[SUM_W-1:0];

  assign out_free     = !out_valid || !out_stall;
  assign advance      = s1_valid_r && (!last || out_free);
  assign verdict_load = advance && last;

  always_comb begin
    sum_nxt  = sum_r;
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    rej_item = rej_r;
    oor_item = oor_r;
    if (elem_ext >= n_eff) begin
      oor_item = 1'b1;
      rej_item = 1'b1;
    end else begin
      sum_nxt = sum_idx;
      if ((sum_mod == '0) || seen_r[sum_idx] || ((sum_mod == n_half) && !last)) begin
        rej_item = 1'b1;
      end else begin
        seen_nxt[sum_idx] = 1'b1;
      end
    end
    rej_nxt = rej_item;
    oor_nxt = oor_item;
    if (last) begin
      // verdict issued, start a fresh ordering
      sum_nxt  = '0;
      seen_nxt = '0;
      pos_nxt  = '0;
      rej_nxt  = 1'b0;
      oor_nxt  = 1'b0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      seen_r <= '0;
      pos_r  <= '0;
      rej_r  <= 1'b0;
      oor_r  <= 1'b0;
    end else if (advance) begin
      sum_r  <= sum_nxt;
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
      rej_r  <= rej_nxt;
      oor_r  <= oor_nxt;
    end
  end

  // result register
  logic out_valid_r;
  logic out_constructive_r;
  logic out_bad_element_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (verdict_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict_load) begin
      out_constructive_r <= !rej_item;
      out_bad_element_r  <= oor_item;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_constructive = out_constructive_r;
  assign out_bad_element  = out_bad_element_r;

  // checks
  `ASSERT_CLKD(a_stall_needs_item, in_stall |-> s1_valid_r, "input stalled with empty stage")
  `ASSERT_CLKD(a_no_overwrite, verdict_load |-> out_free, "verdict overwrote a pending one")
  `ASSERT_CLKD(a_clear_after_verdict,
               verdict_load |=> (pos_r == '0) && (seen_r == '0) && !rej_r && !oor_r,
               "state not cleared after verdict")
  `ASSERT_CLKD(a_zero_never_seen, !seen_r[0], "zero partial sum recorded in bitmap")

endmodule
